// File: src/bitmap_page_allocator_core_defines.svh
// ----------------------------------------------------------------------------
// bitmap page allocator assertion macros
// shared property wrappers, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_CORE_DEFINES_SVH

// consequent must hold in the same cycle
`define BPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the following cycle
`define BPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// shared types, widths and helpers of the bitmap page allocator
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int DEF_MAX_PAGES = 65536;
    localparam int CMD_W         = 2;
    localparam int PAGE_IDX_W    = 16;
    localparam int COUNT_W       = 17;
    localparam int STATUS_W      = 2;
    localparam int WORD_BITS     = 64;
    localparam int BIT_W         = 6;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [COUNT_W-1:0] PAGE_COUNT_RST = COUNT_W'(65536);

    // register index carried in paddr[2]
    localparam logic REG_PAGE_COUNT = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_OOM   = 2'd1,
        STAT_SAME  = 2'd2,
        STAT_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PREP,
        S_SCAN,
        S_UPD
    } fsm_state_t;

    // position of the lowest set bit of a bitmap word
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (w[i])
            begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// File: src/bpa_ifs.sv
// ----------------------------------------------------------------------------
// bpa interfaces
// command channel and result channel of the bitmap page allocator
// ----------------------------------------------------------------------------
interface bpa_cmd_if import bpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CMD_W-1:0]      command;
    logic [PAGE_IDX_W-1:0] page_index;

    modport source (output valid, output command, output page_index, input ready);
    modport sink   (input valid, input command, input page_index, output ready);
endinterface

interface bpa_res_if import bpa_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [PAGE_IDX_W-1:0] granted_index;
    logic [COUNT_W-1:0]    free_count;

    modport source (output valid, output status, output granted_index, output free_count,
                    input ready);
    modport sink   (input valid, input status, input granted_index, input free_count,
                    output ready);
endinterface

// File: src/bpa_rem.sv
// ----------------------------------------------------------------------------
// bpa_rem
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module bpa_rem import bpa_pkg::*;
#(
    parameter int IDX_W = COUNT_W
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [PAGE_IDX_W-1:0] dividend,
    input  logic [IDX_W-1:0]      divisor,
    output logic                  done,
    output logic [PAGE_IDX_W-1:0] remainder
);

    localparam int STEP_W = $clog2(PAGE_IDX_W);

    logic                  busy_reg,  busy_next;
    logic                  done_reg,  done_next;
    logic [STEP_W-1:0]     step_reg,  step_next;
    logic [PAGE_IDX_W-1:0] dvd_reg,   dvd_next;
    logic [IDX_W-1:0]      part_reg,  part_next;
    logic [IDX_W:0]        trial;
    logic [IDX_W:0]        div_ext;

    assign div_ext = {1'b0, divisor};
    assign trial   = {part_reg, dvd_reg[PAGE_IDX_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        part_next = part_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            dvd_next  = dividend;
            part_next = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= div_ext)
            begin
                part_next = IDX_W'(trial - div_ext);
            end
            else
            begin
                part_next = IDX_W'(trial);
            end
            dvd_next  = dvd_reg << 1;
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(PAGE_IDX_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        part_reg <= part_next;
    end

    // remainder never exceeds the 16-bit dividend
    assign done      = done_reg;
    assign remainder = part_reg[PAGE_IDX_W-1:0];

endmodule

// File: src/bitmap_page_allocator_core.sv
// Bitmap page-frame allocator with next-fit search. One used bit per page
// lives in a single-port-read bitmap RAM of 64-bit words (MAX_PAGES/64 words).
// After reset a clearing pass writes every word to all ones, one word per
// cycle; commands are held off until it ends, while page_count writes go
// through at any time. Free and reserve read the bitmap word, then update it
// and post the result. Allocate visits up to ceil(count/64)+1 bitmap words,
// bound by the one bitmap read per cycle. When the last granted index is not
// below the page count, a serial remainder step runs before the search. One
// finished result can wait in the output register while the next is
// computed into a holding slot.
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core
// next-fit page frame allocator on a bitmap RAM, APB page_count register
// ----------------------------------------------------------------------------
`include "bitmap_page_allocator_core_defines.svh"

module bitmap_page_allocator_core import bpa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  logic               clk,
    input  logic               rst_n,
    bpa_cmd_if.sink            cmd_in,
    bpa_res_if.source          res_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int IW    = (AW + BIT_W + 1 > COUNT_W) ? AW + BIT_W + 1 : COUNT_W;
    localparam logic [IW-1:0] MAX_P = IW'(MAX_PAGES);

    // ---------------- state ----------------
    fsm_state_t            state_reg, state_next;
    logic [COUNT_W-1:0]    page_count_reg, page_count_next;
    logic [COUNT_W-1:0]    free_reg, free_next;
    logic [PAGE_IDX_W-1:0] lg_reg, lg_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [PAGE_IDX_W-1:0] pidx_reg, pidx_next;
    logic [IW-1:0]         start_reg, start_next;
    logic [AW-1:0]         clr_addr_reg, clr_addr_next;
    logic [AW-1:0]         iss_addr_reg, iss_addr_next;
    logic [AW-1:0]         ev_addr_reg, ev_addr_next;
    logic                  ev_first_reg, ev_first_next;
    logic                  ev_final_reg, ev_final_next;

    logic                  pend_reg, pend_next;
    logic [STATUS_W-1:0]   pend_status_reg, pend_status_next;
    logic [PAGE_IDX_W-1:0] pend_grant_reg, pend_grant_next;
    logic [COUNT_W-1:0]    pend_free_reg, pend_free_next;

    logic                  out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [PAGE_IDX_W-1:0] out_grant_reg, out_grant_next;
    logic [COUNT_W-1:0]    out_free_reg, out_free_next;

    // ---------------- bitmap ram ----------------
    logic [WORD_BITS-1:0]  mem [WORDS];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  mem_re, mem_we;
    logic [AW-1:0]         mem_ra, mem_wa;
    logic [WORD_BITS-1:0]  mem_wd;

    // ---------------- helpers ----------------
    logic                  acc;
    logic                  in_ready;
    cmd_t                  in_cmd;
    logic [IW-1:0]         cnt_act;
    logic [IW-1:0]         cnt_m1;
    logic [IW-1:0]         pidx_ext;
    logic [IW-1:0]         lg_ext;
    logic                  cnt_zero, lg_in, pidx_in;
    logic [AW-1:0]         last_word, w0;
    logic [BIT_W-1:0]      lim_bit, s_lo;
    logic [WORD_BITS-1:0]  lim_mask, pos_mask, cand;
    logic                  scan_hit, scan_end;
    logic [BIT_W-1:0]      hit_bit;
    logic [IW-1:0]         hit_idx;
    logic [COUNT_W-1:0]    free_dec, free_inc;
    logic                  upd_cur, upd_want;
    logic                  out_free;
    logic                  cfg_wr;
    logic                  rem_start, rem_done;
    logic [PAGE_IDX_W-1:0] rem_val;

    assign in_cmd    = cmd_t'(cmd_in.command);
    assign acc       = cmd_in.valid && in_ready;
    assign cmd_in.ready = in_ready;

    assign cnt_act   = (IW'(page_count_reg) > MAX_P) ? MAX_P : IW'(page_count_reg);
    assign cnt_m1    = cnt_act - 1'b1;
    assign cnt_zero  = (cnt_act == '0);
    assign pidx_ext  = IW'(cmd_in.page_index);
    assign lg_ext    = IW'(lg_reg);
    assign lg_in     = (lg_ext < cnt_act);
    assign pidx_in   = (pidx_ext < cnt_act);

    assign last_word = cnt_m1[AW+BIT_W-1:BIT_W];
    assign lim_bit   = cnt_m1[BIT_W-1:0];
    assign w0        = start_reg[AW+BIT_W-1:BIT_W];
    assign s_lo      = start_reg[BIT_W-1:0];

    // bits past the page count in the last word never take part
    assign lim_mask  = (ev_addr_reg == last_word) ? ({WORD_BITS{1'b1}} >> (~lim_bit))
                                                  : {WORD_BITS{1'b1}};
    // first visit of the start word looks upward, the wrap-around visit downward
    always_comb
    begin
        if (ev_first_reg)
        begin
            pos_mask = {WORD_BITS{1'b1}} << s_lo;
        end
        else if (ev_final_reg)
        begin
            pos_mask = ~({WORD_BITS{1'b1}} << s_lo);
        end
        else
        begin
            pos_mask = {WORD_BITS{1'b1}};
        end
    end

    assign cand     = ~rd_data_reg & lim_mask & pos_mask;
    assign scan_hit = |cand;
    assign hit_bit  = lowest_set(cand);
    assign hit_idx  = IW'({ev_addr_reg, hit_bit});
    assign scan_end = scan_hit || ev_final_reg;

    assign free_dec = (free_reg != '0) ? free_reg - 1'b1 : free_reg;
    assign free_inc = (free_reg != '1) ? free_reg + 1'b1 : free_reg;

    assign upd_cur  = rd_data_reg[pidx_reg[BIT_W-1:0]];
    assign upd_want = (cmd_reg == CMD_RESERVE);

    assign out_free = !out_valid_reg || res_out.ready;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_PAGE_COUNT) ? PDATA_W'(page_count_reg) : '0;

    always_comb
    begin
        page_count_next = page_count_reg;
        if (cfg_wr && paddr[2] == REG_PAGE_COUNT)
        begin
            page_count_next = pwdata[COUNT_W-1:0];
        end
    end

    // ---------------- remainder unit ----------------
    bpa_rem #(
        .IDX_W (IW)
    ) u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (rem_start),
        .dividend  (lg_reg),
        .divisor   (cnt_act),
        .done      (rem_done),
        .remainder (rem_val)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == AW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (acc)
                begin
                    unique case (in_cmd) inside
                        CMD_ALLOC:
                        begin
                            if (cnt_zero)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (lg_in)
                            begin
                                state_next = S_PREP;
                            end
                            else
                            begin
                                state_next = S_MOD;
                            end
                        end
                        CMD_FREE, CMD_RESERVE:
                        begin
                            state_next = pidx_in ? S_UPD : S_IDLE;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (rem_done)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = S_IDLE;
                end
            end
            S_UPD:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        in_ready         = 1'b0;
        free_next        = free_reg;
        lg_next          = lg_reg;
        cmd_next         = cmd_reg;
        pidx_next        = pidx_reg;
        start_next       = start_reg;
        clr_addr_next    = clr_addr_reg;
        iss_addr_next    = iss_addr_reg;
        ev_addr_next     = ev_addr_reg;
        ev_first_next    = ev_first_reg;
        ev_final_next    = ev_final_reg;
        pend_next        = pend_reg;
        pend_status_next = pend_status_reg;
        pend_grant_next  = pend_grant_reg;
        pend_free_next   = pend_free_reg;
        mem_re           = 1'b0;
        mem_ra           = iss_addr_reg;
        mem_we           = 1'b0;
        mem_wa           = ev_addr_reg;
        mem_wd           = rd_data_reg;
        rem_start        = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_wa        = clr_addr_reg;
                mem_wd        = {WORD_BITS{1'b1}};
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            S_IDLE:
            begin
                in_ready = !pend_reg;
                if (acc)
                begin
                    cmd_next  = in_cmd;
                    pidx_next = cmd_in.page_index;
                    unique case (in_cmd) inside
                        CMD_ALLOC:
                        begin
                            if (cnt_zero)
                            begin
                                pend_next        = 1'b1;
                                pend_status_next = STAT_OOM;
                                pend_grant_next  = '0;
                                pend_free_next   = free_reg;
                            end
                            else if (lg_in)
                            begin
                                start_next = lg_ext;
                            end
                            else
                            begin
                                rem_start = 1'b1;
                            end
                        end
                        CMD_FREE, CMD_RESERVE:
                        begin
                            if (pidx_in)
                            begin
                                mem_re = 1'b1;
                                mem_ra = pidx_ext[AW+BIT_W-1:BIT_W];
                            end
                            else
                            begin
                                pend_next        = 1'b1;
                                pend_status_next = STAT_RANGE;
                                pend_grant_next  = '0;
                                pend_free_next   = free_reg;
                            end
                        end
                        default:
                        begin
                            pend_next        = 1'b1;
                            pend_status_next = STAT_DONE;
                            pend_grant_next  = '0;
                            pend_free_next   = free_reg;
                        end
                    endcase
                end
            end
            S_MOD:
            begin
                if (rem_done)
                begin
                    start_next = IW'(rem_val);
                end
            end
            S_PREP:
            begin
                mem_re        = 1'b1;
                mem_ra        = w0;
                ev_addr_next  = w0;
                ev_first_next = 1'b1;
                ev_final_next = 1'b0;
                iss_addr_next = (w0 == last_word) ? '0 : w0 + 1'b1;
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    mem_we           = 1'b1;
                    mem_wd           = rd_data_reg | (WORD_BITS'(1) << hit_bit);
                    lg_next          = hit_idx[PAGE_IDX_W-1:0];
                    free_next        = free_dec;
                    pend_next        = 1'b1;
                    pend_status_next = STAT_DONE;
                    pend_grant_next  = hit_idx[PAGE_IDX_W-1:0];
                    pend_free_next   = free_dec;
                end
                else if (ev_final_reg)
                begin
                    pend_next        = 1'b1;
                    pend_status_next = STAT_OOM;
                    pend_grant_next  = '0;
                    pend_free_next   = free_reg;
                end
                else
                begin
                    // keep one word read ahead of the evaluation
                    mem_re        = 1'b1;
                    mem_ra        = iss_addr_reg;
                    ev_addr_next  = iss_addr_reg;
                    ev_first_next = 1'b0;
                    ev_final_next = (iss_addr_reg == w0);
                    iss_addr_next = (iss_addr_reg == last_word) ? '0 : iss_addr_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                pend_next       = 1'b1;
                pend_grant_next = '0;
                mem_wa          = pidx_reg[AW+BIT_W-1:BIT_W];
                if (upd_cur == upd_want)
                begin
                    pend_status_next = STAT_SAME;
                    pend_free_next   = free_reg;
                end
                else
                begin
                    mem_we           = 1'b1;
                    pend_status_next = STAT_DONE;
                    if (upd_want)
                    begin
                        mem_wd         = rd_data_reg | (WORD_BITS'(1) << pidx_reg[BIT_W-1:0]);
                        free_next      = free_dec;
                        pend_free_next = free_dec;
                    end
                    else
                    begin
                        mem_wd         = rd_data_reg & ~(WORD_BITS'(1) << pidx_reg[BIT_W-1:0]);
                        free_next      = free_inc;
                        pend_free_next = free_inc;
                    end
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase

        // holding slot drains into the output register
        if (pend_reg && out_free)
        begin
            pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_grant_next  = out_grant_reg;
        out_free_next   = out_free_reg;
        if (pend_reg && out_free)
        begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_grant_next  = pend_grant_reg;
            out_free_next   = pend_free_reg;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.status        = out_status_reg;
    assign res_out.granted_index = out_grant_reg;
    assign res_out.free_count    = out_free_reg;

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            page_count_reg <= PAGE_COUNT_RST;
            free_reg       <= '0;
            lg_reg         <= '0;
            clr_addr_reg   <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            page_count_reg <= page_count_next;
            free_reg       <= free_next;
            lg_reg         <= lg_next;
            clr_addr_reg   <= clr_addr_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pidx_reg        <= pidx_next;
        start_reg       <= start_next;
        iss_addr_reg    <= iss_addr_next;
        ev_addr_reg     <= ev_addr_next;
        ev_first_reg    <= ev_first_next;
        ev_final_reg    <= ev_final_next;
        pend_status_reg <= pend_status_next;
        pend_grant_reg  <= pend_grant_next;
        pend_free_reg   <= pend_free_next;
        out_status_reg  <= out_status_next;
        out_grant_reg   <= out_grant_next;
        out_free_reg    <= out_free_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    // ---------------- assertions ----------------
    `BPA_ASSERT_NOW(a_no_cmd_while_clearing, state_reg == S_CLEAR, !cmd_in.ready, "command taken during clearing pass")
    `BPA_ASSERT_NEXT(a_accept_blocks_next, acc, !cmd_in.ready, "two items accepted back to back")
    `BPA_ASSERT_NEXT(a_pending_held, pend_reg && out_valid_reg && !res_out.ready, pend_reg && $stable(pend_grant_reg) && $stable(pend_status_reg), "held result lost or changed")
    `BPA_ASSERT_NEXT(a_scan_stops, state_reg == S_SCAN && ev_final_reg, state_reg != S_SCAN, "search ran past the wrap-around word")
    `BPA_ASSERT_NOW(a_rw_same_word, mem_we && mem_re && mem_wa == mem_ra, state_reg == S_SCAN, "read and write of one word outside the search")

endmodule

// File: bench/bpa_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpa_checker
// watches the command, result and register ports of the page allocator,
// keeps its own copy of the bitmap and counters, and compares every result
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*;
#(
    parameter int MAX_PAGES = DEF_MAX_PAGES
)
(
    input  logic               clk,
    input  logic               rst_n,
    bpa_cmd_if                 cmd_mon,
    bpa_res_if                 res_mon,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output int                 mismatches,
    output int                 pending_results
);

    typedef struct packed {
        status_t               status;
        logic [PAGE_IDX_W-1:0] granted;
        logic [COUNT_W-1:0]    free_count;
    } page_result_t;

    bit                    used_map [MAX_PAGES];
    logic [PAGE_IDX_W-1:0] last_grant;
    logic [COUNT_W-1:0]    free_left;
    logic [COUNT_W-1:0]    pages_reg;
    page_result_t          expected_results [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic page_result_t predict_page_op(input logic [CMD_W-1:0] op,
                                                     input logic [PAGE_IDX_W-1:0] pidx);
        page_result_t r;
        int           lim;
        int           idx;
        bit           want_used;
        lim       = (pages_reg > MAX_PAGES) ? MAX_PAGES : int'(pages_reg);
        r.status  = STAT_DONE;
        r.granted = '0;
        if (op == CMD_ALLOC)
        begin
            r.status = STAT_OOM;
            if (lim != 0)
            begin
                // next fit: resume at the last grant, folded into the active range
                idx = int'(last_grant) % lim;
                for (int i = 0; i < lim; i++)
                begin
                    if (!used_map[idx])
                    begin
                        used_map[idx] = 1'b1;
                        last_grant    = PAGE_IDX_W'(idx);
                        if (free_left != '0)
                        begin
                            free_left--;
                        end
                        r.granted = PAGE_IDX_W'(idx);
                        r.status  = STAT_DONE;
                        break;
                    end
                    idx++;
                    if (idx == lim)
                    begin
                        idx = 0;
                    end
                end
            end
        end
        else if (op == CMD_FREE || op == CMD_RESERVE)
        begin
            want_used = (op == CMD_RESERVE);
            if (int'(pidx) >= lim)
            begin
                r.status = STAT_RANGE;
            end
            else if (used_map[pidx] == want_used)
            begin
                r.status = STAT_SAME;
            end
            else
            begin
                used_map[pidx] = want_used;
                if (want_used)
                begin
                    if (free_left != '0)
                    begin
                        free_left--;
                    end
                end
                else if (free_left != '1)
                begin
                    free_left++;
                end
            end
        end
        r.free_count = free_left;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        page_result_t exp_res;
        if (!rst_n)
        begin
            used_map        = '{default: 1'b1};
            last_grant      = '0;
            free_left       = '0;
            pages_reg       = PAGE_COUNT_RST;
            expected_results.delete();
            pending_results = 0;
            mismatches      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_PAGE_COUNT)
            begin
                pages_reg = pwdata[COUNT_W-1:0];
            end
            if (res_mon.valid && res_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result item with nothing outstanding");
                end
                else
                begin
                    exp_res = expected_results.pop_front();
                    if (res_mon.status !== exp_res.status)
                    begin
                        report_mismatch($sformatf("status got %0d, want %0d",
                                                  res_mon.status, exp_res.status));
                    end
                    if (res_mon.granted_index !== exp_res.granted)
                    begin
                        report_mismatch($sformatf("granted_index got %0d, want %0d",
                                                  res_mon.granted_index, exp_res.granted));
                    end
                    if (res_mon.free_count !== exp_res.free_count)
                    begin
                        report_mismatch($sformatf("free_count got %0d, want %0d",
                                                  res_mon.free_count, exp_res.free_count));
                    end
                end
            end
            if (cmd_mon.valid && cmd_mon.ready)
            begin
                expected_results.push_back(predict_page_op(cmd_mon.command,
                                                           cmd_mon.page_index));
            end
            pending_results = expected_results.size();
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives allocate, free and reserve items and page_count writes into the
// page allocator, with random gaps and back-pressure; a checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------
module testbench import bpa_pkg::*; ();

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int RANDOM_ITEMS = 580;
    localparam int DRAIN_CYCLES = 1100;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    bit                 quiet;
    int                 cycle_count = 0;
    int                 mismatches;
    int                 pending_results;
    int                 active_pages;

    bpa_cmd_if cmd_if ();
    bpa_res_if res_if ();

    bitmap_page_allocator_core u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_in  (cmd_if),
        .res_out (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bpa_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_mon         (cmd_if),
        .res_mon         (res_if),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // result back-pressure
    always @(negedge clk)
    begin
        res_if.ready = quiet || ($urandom_range(99) >= 32);
    end

    // entered and left at a falling edge
    task automatic send_page_op(input logic [CMD_W-1:0] op,
                                input logic [PAGE_IDX_W-1:0] pidx);
        if (!quiet)
        begin
            while ($urandom_range(99) < 32)
            begin
                cmd_if.valid = 1'b0;
                @(negedge clk);
            end
        end
        cmd_if.valid      = 1'b1;
        cmd_if.command    = op;
        cmd_if.page_index = pidx;
        @(posedge clk);
        while (!cmd_if.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic wait_idle();
        cmd_if.valid = 1'b0;
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_page_count(input logic [COUNT_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_PAGE_COUNT, 2'b00};
        pwdata  = PDATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        active_pages = (value > DEF_MAX_PAGES) ? DEF_MAX_PAGES : int'(value);
    endtask

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int               sent_random;
        int               phase;
        int               roll;
        int               batch;
        logic [COUNT_W-1:0] new_count;
        logic [CMD_W-1:0]   op;
        logic [PAGE_IDX_W-1:0] pidx;

        rst_n             = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.command    = CMD_ALLOC;
        cmd_if.page_index = '0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        quiet             = 1'b0;
        active_pages      = DEF_MAX_PAGES;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // full bitmap at the reset page count: one long fruitless scan
        send_page_op(CMD_ALLOC, '0);
        send_page_op(CMD_FREE, 16'hFFFF);
        send_page_op(CMD_FREE, 16'hFFFF);
        send_page_op(CMD_FREE, 16'h0000);
        send_page_op(CMD_ALLOC, 16'hFFFF);
        send_page_op(CMD_ALLOC, 16'h0000);
        send_page_op(CMD_RESERVE, 16'hFFFF);
        send_page_op(CMD_FREE, 16'hFFFF);
        send_page_op(CMD_FREE, 16'd100);
        send_page_op(CMD_NOP, 16'hFFFF);

        // no pages managed at all
        wait_idle();
        write_page_count('0);
        send_page_op(CMD_ALLOC, '0);
        send_page_op(CMD_FREE, '0);
        send_page_op(CMD_RESERVE, 16'd5);

        // oversized count saturates
        wait_idle();
        write_page_count('1);
        send_page_op(CMD_FREE, 16'd1234);
        send_page_op(CMD_ALLOC, '0);

        // last grant now far above the count, scan starts at its remainder
        wait_idle();
        write_page_count(COUNT_W'(37));
        send_page_op(CMD_FREE, 16'd10);
        send_page_op(CMD_FREE, 16'd30);
        send_page_op(CMD_ALLOC, '0);
        send_page_op(CMD_RESERVE, 16'd30);
        send_page_op(CMD_RESERVE, 16'd37);

        wait_idle();
        write_page_count(COUNT_W'(1));
        send_page_op(CMD_FREE, '0);
        send_page_op(CMD_ALLOC, '0);
        send_page_op(CMD_ALLOC, '0);
        send_page_op(CMD_RESERVE, 16'd1);

        sent_random = 0;
        phase       = 0;
        while (sent_random < RANDOM_ITEMS)
        begin
            wait_idle();
            quiet = (phase >= 8 && phase < 11);
            roll  = $urandom_range(99);
            if (roll < 6)
            begin
                new_count = '0;
            end
            else if (roll < 10)
            begin
                new_count = COUNT_W'(DEF_MAX_PAGES);
            end
            else if (roll < 14)
            begin
                new_count = COUNT_W'($urandom_range(DEF_MAX_PAGES + 1, 131071));
            end
            else if (roll < 26)
            begin
                new_count = COUNT_W'(64 * $urandom_range(1, 5));
            end
            else
            begin
                new_count = COUNT_W'($urandom_range(1, 300));
            end
            write_page_count(new_count);

            // big counts make allocate slow, so keep those batches short
            batch = (active_pages == DEF_MAX_PAGES) ? 8 : $urandom_range(16, 32);
            for (int i = 0; i < batch; i++)
            begin
                roll = $urandom_range(99);
                if (i < batch / 4 || (roll >= 45 && roll < 72))
                begin
                    op = CMD_FREE;
                end
                else if (roll < 45)
                begin
                    op = CMD_ALLOC;
                end
                else if (roll < 90)
                begin
                    op = CMD_RESERVE;
                end
                else
                begin
                    op = CMD_NOP;
                end
                if (active_pages > 0 && $urandom_range(99) < 85)
                begin
                    pidx = PAGE_IDX_W'($urandom_range(0, active_pages - 1));
                end
                else
                begin
                    pidx = PAGE_IDX_W'($urandom);
                end
                send_page_op(op, pidx);
                sent_random++;
            end
            phase++;
        end

        wait_idle();
        quiet = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
